// File: sv/shannon_entropy_of_counts_assert.svh
// Assertion macros for the entropy block.
`ifndef SHANNON_ENTROPY_OF_COUNTS_ASSERT_SVH
`define SHANNON_ENTROPY_OF_COUNTS_ASSERT_SVH

// Implication that must hold at every clock edge outside reset.
`define SE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/se_pkg.sv
// Package: widths, constants, types and log2 step helpers for the entropy block.
`default_nettype none
package se_pkg;
	localparam int MaxClasses = 256;
	localparam int CountBits  = 16;
	localparam int FracBits   = 16;
	localparam int TotBits    = 24;
	localparam int WsumBits   = 44;
	localparam int EntBits    = 20;
	localparam int ClsBits    = 13;
	localparam int LogBits    = 5 + FracBits;
	localparam int QDepth     = 4;
	localparam int QPtrBits   = 2;

	localparam logic [TotBits-1:0]  TotMax  = '1;
	localparam logic [WsumBits-1:0] WsumMax = '1;
	localparam logic [EntBits-1:0]  EntMax  = '1;

	// Work item from front to back.
	typedef struct packed {
		logic [CountBits-1:0] cnt;
		logic                 take;
		logic                 last;
	} item_t;

	// Back-end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE, ST_CLOG, ST_CMUL, ST_CACC, ST_TLOG, ST_DIV, ST_SUB, ST_OUT
	} bst_t;

	// Index of the highest set bit of a 32-bit value.
	function automatic logic [4:0] msb_idx(input logic [31:0] x);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < 32; i++)
			if (x[i]) n = 5'(i);
		return n;
	endfunction

	// One fraction step: square the Q1.31 mantissa, giving a Q2.31 result for the caller to renormalize.
	function automatic logic [32:0] sq_step(input logic [31:0] m);
		logic [63:0] p;
		logic [32:0] r;
		p = 64'(m) * 64'(m);
		r = p[63:31];
		return r;
	endfunction
endpackage
`default_nettype wire

// File: sv/se_if.sv
// Valid/ready channel interface.
`default_nettype none
interface se_if #(parameter int W = 1) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/se_front.sv
// Front end: accept counts, track classes and push work items to the queue.
`default_nettype none
module se_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [15:0]   in_cnt,
	input  wire logic          in_last,
	output se_pkg::item_t      q_item,
	output logic               q_push,
	input  wire logic          q_full
);
	import se_pkg::*;

	logic [ClsBits-1:0] classes_q;
	logic               take;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;
	assign take     = classes_q < ClsBits'(MaxClasses);
	assign q_item   = '{cnt: in_cnt[CountBits-1:0], take: take, last: in_last};

	// Count classes, clear on the last beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			classes_q <= '0;
		end else if (q_push) begin
			if (in_last) classes_q <= '0;
			else if (take) classes_q <= classes_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

// File: sv/se_queue.sv
// Short FIFO between front and back.
`default_nettype none
module se_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  se_pkg::item_t wdata,
	output logic          full,
	input  wire logic     pop,
	output se_pkg::item_t rdata,
	output logic          empty
);
	import se_pkg::*;

	item_t              mem_q [QDepth];
	logic [QPtrBits:0]  wp_q, rp_q;

	assign empty = wp_q == rp_q;
	assign full  = (wp_q[QPtrBits] != rp_q[QPtrBits]) &&
		(wp_q[QPtrBits-1:0] == rp_q[QPtrBits-1:0]);
	assign rdata = mem_q[rp_q[QPtrBits-1:0]];

	// Write entries.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q[QPtrBits-1:0]] <= wdata;
	end

	// Advance pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

// File: sv/se_back.sv
// Back end: log2, accumulate, divide and emit the entropy result.
`default_nettype none
module se_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  se_pkg::item_t     q_item,
	input  wire logic         q_empty,
	output logic              q_pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [19:0]       ent,
	output logic [23:0]       tot,
	output logic              ovf
);
	import se_pkg::*;

	bst_t st_q, st_d;
	logic [TotBits-1:0]  tot_q;
	logic [WsumBits-1:0] wsum_q;
	logic                ovf_q;
	logic                last_q;
	logic [CountBits-1:0] c_q;
	logic [31:0]          m_q;
	logic [4:0]           n_q;
	logic [FracBits-1:0]  frac_q;
	logic [5:0]           step_q;
	logic [WsumBits-1:0]  rem_q, quo_q;
	logic [LogBits-1:0]   lt_q;
	logic [WsumBits+CountBits-1:0] prod_q;
	logic [32:0]          sq;
	logic [LogBits-1:0]   lg;
	logic [TotBits:0]     tsum;
	logic [TotBits-1:0]   tot_nx;
	logic [WsumBits:0]    wadd;
	logic [WsumBits:0]    rtry;
	logic                 load, start_log;
	logic [31:0]          lsrc;

	assign sq   = sq_step(m_q);
	assign lg   = {n_q, frac_q};
	assign tsum = {1'b0, tot_q} + (TotBits+1)'(c_q);
	// Total after folding in the current count, saturated.
	assign tot_nx = (c_q == '0) ? tot_q : (tsum[TotBits] ? TotMax : tsum[TotBits-1:0]);
	assign wadd = {1'b0, wsum_q} + {1'b0, prod_q[WsumBits-1:0]};
	assign rtry = {rem_q, quo_q[WsumBits-1]} - (WsumBits+1)'(tot_q);
	assign q_pop = (st_q == ST_IDLE) && !q_empty;

	// Sequence one queue entry at a time.
	always_comb begin
		st_d = st_q;
		load = 1'b0;
		start_log = 1'b0;
		lsrc = 32'(c_q);
		unique case (st_q)
			ST_IDLE: if (!q_empty) begin
				load = 1'b1;
				st_d = ST_CLOG;
			end
			ST_CLOG: if (step_q == 6'(FracBits)) st_d = ST_CMUL;
			ST_CMUL: st_d = ST_CACC;
			ST_CACC: begin
				if (last_q) begin
					st_d = (tot_nx == '0) ? ST_OUT : ST_TLOG;
					start_log = tot_nx != '0;
					lsrc = 32'(tot_nx);
				end else st_d = ST_IDLE;
			end
			ST_TLOG: if (step_q == 6'(FracBits)) st_d = ST_DIV;
			ST_DIV: if (step_q == 6'(WsumBits)) st_d = ST_SUB;
			ST_SUB: st_d = ST_OUT;
			ST_OUT: if (out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			tot_q  <= '0;
			wsum_q <= '0;
			ovf_q  <= 1'b0;
			last_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load) begin
				last_q <= q_item.last;
				if (!q_item.take) ovf_q <= 1'b1;
			end
			if (st_q == ST_CACC && c_q != '0) begin
				tot_q  <= tot_nx;
				wsum_q <= (wadd[WsumBits] || prod_q[WsumBits+CountBits-1:WsumBits] != '0)
					? WsumMax : wadd[WsumBits-1:0];
			end
			if (st_q == ST_OUT && out_ready) begin
				tot_q  <= '0;
				wsum_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	// Datapath: log2 iterations, multiply, restoring divide, subtract.
	always_ff @(posedge clk) begin
		if (load) begin
			c_q    <= q_item.take ? q_item.cnt : '0;
			n_q    <= msb_idx(32'(q_item.take ? q_item.cnt : '0));
			m_q    <= 32'(q_item.take ? q_item.cnt : '0) <<
				(5'd31 - msb_idx(32'(q_item.take ? q_item.cnt : '0)));
			frac_q <= '0;
			step_q <= '0;
		end else if (start_log) begin
			n_q    <= msb_idx(lsrc);
			m_q    <= lsrc << (5'd31 - msb_idx(lsrc));
			frac_q <= '0;
			step_q <= '0;
		end else if ((st_q == ST_CLOG || st_q == ST_TLOG) && step_q != 6'(FracBits)) begin
			frac_q <= {frac_q[FracBits-2:0], sq[32]};
			m_q    <= sq[32] ? sq[32:1] : sq[31:0];
			step_q <= step_q + 1'b1;
		end else if (st_q == ST_TLOG) begin
			lt_q   <= lg;
			rem_q  <= '0;
			quo_q  <= wsum_q;
			step_q <= '0;
		end else if (st_q == ST_DIV && step_q != 6'(WsumBits)) begin
			if (!rtry[WsumBits]) begin
				rem_q <= rtry[WsumBits-1:0];
				quo_q <= {quo_q[WsumBits-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WsumBits-2:0], quo_q[WsumBits-1]};
				quo_q <= {quo_q[WsumBits-2:0], 1'b0};
			end
			step_q <= step_q + 1'b1;
		end
		if (st_q == ST_CMUL) prod_q <= (WsumBits+CountBits)'(c_q) * (WsumBits+CountBits)'(lg);
		if (st_q == ST_SUB) begin
			if (WsumBits'(lt_q) <= quo_q) ent <= '0;
			else if (WsumBits'(lt_q) - quo_q > WsumBits'(EntMax)) ent <= EntMax;
			else ent <= EntBits'(WsumBits'(lt_q) - quo_q);
		end else if (st_q == ST_CACC && tot_nx == '0) ent <= '0;
	end

	assign out_valid = st_q == ST_OUT;
	assign tot = tot_q;
	assign ovf = ovf_q;
endmodule
`default_nettype wire

// File: sv/shannon_entropy_of_counts.sv
// Top level: base-2 Shannon entropy of a streamed class histogram.
// Input channel (sink): one class count per beat, last_count marks the
// final count of a distribution. Output channel (source): one result beat per
// distribution with entropy_fixed (16 fraction bits), total_count and
// too_many_classes. The front accepts beats into a 4-entry queue, so input
// keeps flowing while the back works or the output stalls.
// The back end handles one queued count in the states pop, iterated log2
// (one squaring step per fraction bit), multiply and accumulate. On the
// last beat it then takes log2 of the total, runs the bit-serial divide
// and the subtract (for a zero total it skips these and gives entropy
// zero), then holds the result until taken.
// Reset clears the control state and the queue pointers; a stalled
// receiver holds the result and the back end, and the input stalls once
// the queue fills.
`default_nettype none
`include "shannon_entropy_of_counts_assert.svh"
module shannon_entropy_of_counts (
	input  wire logic clk,
	input  wire logic arst_n,
	se_if.sink        in_ch,
	se_if.source      out_ch
);
	import se_pkg::*;

	item_t qi, qo;
	logic  push, pop, full, empty;
	logic [19:0] ent;
	logic [23:0] tot;
	logic        ovf;

	se_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_cnt(in_ch.data[15:0]), .in_last(in_ch.data[16]),
		.q_item(qi), .q_push(push), .q_full(full));

	se_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(qi), .full(full),
		.pop(pop), .rdata(qo), .empty(empty));

	se_back u_back (
		.clk(clk), .arst_n(arst_n), .q_item(qo), .q_empty(empty), .q_pop(pop),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.ent(ent), .tot(tot), .ovf(ovf));

	assign out_ch.data = {ovf, tot, ent};

	`SE_ASSERT_IMPL(a_no_push_full, clk, arst_n, full, !push, "push into full queue")
	`SE_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, empty, !pop, "pop from empty queue")
	`SE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.data), "result dropped under stall")
endmodule
`default_nettype wire
